>>> design/mctc_pkg.sv
package mctc_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int CHAN_W      = 16;
    localparam int PROD_W      = 2 * CHAN_W;
    localparam int DIV_STAGES  = CHAN_W;

    // function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_chan x;
        t_chan y;
        t_chan z;
    } t_pix;

    typedef struct packed {
        t_prod x;
        t_prod y;
        t_prod z;
    } t_prod3;

endpackage

>>> design/mctc_if.sv
interface mctc_in_if import mctc_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  func;
    t_chan table_index;
    t_chan table_value;
    t_chan chan_x;
    t_chan chan_y;
    t_chan chan_z;

    modport source (output valid, func, table_index, table_value, chan_x, chan_y, chan_z,
                    input ready);
    modport sink   (input valid, func, table_index, table_value, chan_x, chan_y, chan_z,
                    output ready);
endinterface

interface mctc_out_if import mctc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_chan out_x;
    t_chan out_y;
    t_chan out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

>>> design/mctc_ram.sv
module mctc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/mctc_div.sv
module mctc_div import mctc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_prod3 i_prod,
    input  t_chan  i_peak,
    output logic   o_valid,
    input  logic   i_ready,
    output t_pix   o_quo
);
    // each lane holds {remainder, dividend low bits / quotient bits}
    logic   r_vld  [DIV_STAGES+1];
    t_prod3 r_work [DIV_STAGES+1];
    t_chan  r_div  [DIV_STAGES+1];
    logic   mv     [DIV_STAGES+1];

    function automatic t_prod div_step(input t_prod w, input t_chan d);
        logic [CHAN_W:0] t;
        logic [CHAN_W:0] s;
        logic            b;
        t = {w[PROD_W-1:CHAN_W], w[CHAN_W-1]};
        s = t - {1'b0, d};
        b = (t >= {1'b0, d});
        if (b) begin
            div_step = {s[CHAN_W-1:0], w[CHAN_W-2:0], 1'b1};
        end else begin
            div_step = {t[CHAN_W-1:0], w[CHAN_W-2:0], 1'b0};
        end
    endfunction

    always_comb begin
        mv[DIV_STAGES] = r_vld[DIV_STAGES] && i_ready;
        for (int k = DIV_STAGES - 1; k >= 0; k--) begin
            mv[k] = r_vld[k] && (!r_vld[k+1] || mv[k+1]);
        end
    end

    assign o_ready = !r_vld[0] || mv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (o_ready) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k <= DIV_STAGES; k++) begin
                if (!r_vld[k] || mv[k]) begin
                    r_vld[k] <= mv[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work[0] <= i_prod;
            r_div[0]  <= i_peak;
        end
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (mv[k-1] && (!r_vld[k] || mv[k])) begin
                r_work[k].x <= div_step(r_work[k-1].x, r_div[k-1]);
                r_work[k].y <= div_step(r_work[k-1].y, r_div[k-1]);
                r_work[k].z <= div_step(r_work[k-1].z, r_div[k-1]);
                r_div[k]    <= r_div[k-1];
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES];
    assign o_quo.x = r_work[DIV_STAGES].x[CHAN_W-1:0];
    assign o_quo.y = r_work[DIV_STAGES].y[CHAN_W-1:0];
    assign o_quo.z = r_work[DIV_STAGES].z[CHAN_W-1:0];
endmodule

>>> design/max_channel_tone_curve.sv
// channel | dir | transfer content
// i_pix   | in  | func, table_index, table_value, chan_x, chan_y, chan_z
// o_pix   | out | out_x, out_y, out_z (one per pixel, none for a table write)
//
// one item per cycle sustained while o_pix is ready; a pixel result passes, in order:
// curve ram read, three 16x16 multiplies, divider input register,
// 16-stage restoring divider. the curve table is one ram with a registered read
// synchronous active-low reset clears the stage valid bits only; table is undefined
// until written. stages advance independently so bubbles collapse under stall
module max_channel_tone_curve import mctc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mctc_in_if.sink       i_pix,
    mctc_out_if.source    o_pix
);
    localparam logic [CHAN_W:0] DEPTH_EXT = (CHAN_W+1)'(TABLE_DEPTH);

    // stage 1: ram read in flight, pixel and peak held
    logic   r_s1_vld;
    t_pix   r_s1_pix;
    t_chan  r_s1_peak;
    // stage 2: products
    logic   r_s2_vld;
    t_prod3 r_s2_prod;
    t_chan  r_s2_peak;

    logic   s1_mv, s2_mv, div_ready, acc;
    t_chan  peak, n_peak;
    t_chan  gain;
    logic   wr_en, rd_en;
    logic [TBL_AW-1:0] raddr;
    t_pix   quo;

    // next peak: max of the channels, zero raised to one
    always_comb begin
        peak = i_pix.chan_x;
        if (i_pix.chan_y > peak) begin
            peak = i_pix.chan_y;
        end
        if (i_pix.chan_z > peak) begin
            peak = i_pix.chan_z;
        end
        n_peak = (peak == '0) ? CHAN_W'(1) : peak;
    end

    // lookup saturates at the last entry
    always_comb begin
        if ({1'b0, n_peak} >= DEPTH_EXT) begin
            raddr = TBL_AW'(TABLE_DEPTH - 1);
        end else begin
            raddr = n_peak[TBL_AW-1:0];
        end
    end

    assign s2_mv       = r_s2_vld && div_ready;
    assign s1_mv       = r_s1_vld && (!r_s2_vld || s2_mv);
    assign i_pix.ready = !r_s1_vld || s1_mv;
    assign acc         = i_pix.valid && i_pix.ready;
    assign rd_en       = acc && (i_pix.func == FUNC_PIXEL);
    // writes beyond the table are dropped
    assign wr_en       = acc && (i_pix.func == FUNC_WRITE)
                         && ({1'b0, i_pix.table_index} < DEPTH_EXT);

    mctc_ram #(
        .WIDTH (CHAN_W),
        .DEPTH (TABLE_DEPTH)
    ) u_curve (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_pix.table_index[TBL_AW-1:0]),
        .i_wdata (i_pix.table_value),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (gain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (i_pix.ready) begin
                r_s1_vld <= rd_en;
            end
            if (!r_s2_vld || s2_mv) begin
                r_s2_vld <= s1_mv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_pix  <= '{x: i_pix.chan_x, y: i_pix.chan_y, z: i_pix.chan_z};
            r_s1_peak <= n_peak;
        end
        // gain holds in the ram read register while stage 1 waits
        if (s1_mv) begin
            r_s2_prod.x <= PROD_W'(r_s1_pix.x) * PROD_W'(gain);
            r_s2_prod.y <= PROD_W'(r_s1_pix.y) * PROD_W'(gain);
            r_s2_prod.z <= PROD_W'(r_s1_pix.z) * PROD_W'(gain);
            r_s2_peak   <= r_s1_peak;
        end
    end

    // channel <= peak, so every quotient fits in 16 bits
    mctc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_vld),
        .o_ready (div_ready),
        .i_prod  (r_s2_prod),
        .i_peak  (r_s2_peak),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_quo   (quo)
    );

    assign o_pix.out_x = quo.x;
    assign o_pix.out_y = quo.y;
    assign o_pix.out_z = quo.z;
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mctc_pkg::*;

    // one transfer into the block
    typedef struct {
        logic  func;
        t_chan table_index;
        t_chan table_value;
        t_chan chan_x;
        t_chan chan_y;
        t_chan chan_z;
    } t_req;

    // scoreboard: keeps its own curve table and the queue of scaled pixels still owed
    class tone_scoreboard;
        t_chan curve[TABLE_DEPTH];
        t_pix  owed_pix[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        // note an accepted transfer, work out the scaled pixel if any
        function void note_input(t_req r);
            logic [31:0] peak;
            logic [31:0] look;
            logic [31:0] gain;
            t_pix        p;
            if (r.func == FUNC_WRITE) begin
                if (r.table_index < TABLE_DEPTH)
                    curve[r.table_index] = r.table_value;
            end else begin
                peak = r.chan_x;
                if (r.chan_y > peak)
                    peak = r.chan_y;
                if (r.chan_z > peak)
                    peak = r.chan_z;
                if (peak == 0)
                    peak = 1;
                look = (peak >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : peak;
                gain = curve[look];
                p.x = t_chan'((64'(r.chan_x) * gain) / peak);
                p.y = t_chan'((64'(r.chan_y) * gain) / peak);
                p.z = t_chan'((64'(r.chan_z) * gain) / peak);
                owed_pix.push_back(p);
            end
        endfunction

        function void check_result(t_pix got);
            t_pix exp_p;
            if (owed_pix.size() == 0) begin
                $display("%0t: unexpected pixel exp none act %h %h %h",
                         $realtime, got.x, got.y, got.z);
                errors++;
                return;
            end
            exp_p = owed_pix.pop_front();
            if (got.x !== exp_p.x) begin
                $display("%0t: out_x exp %h act %h", $realtime, exp_p.x, got.x);
                errors++;
            end
            if (got.y !== exp_p.y) begin
                $display("%0t: out_y exp %h act %h", $realtime, exp_p.y, got.y);
                errors++;
            end
            if (got.z !== exp_p.z) begin
                $display("%0t: out_z exp %h act %h", $realtime, exp_p.z, got.z);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mctc_in_if  pix_in ();
    mctc_out_if pix_out ();

    max_channel_tone_curve dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in.sink),
        .o_pix   (pix_out.source)
    );

    tone_scoreboard sb;
    logic           hold_off;       // long receiver stall, set by the stimulus side
    bit             written[TABLE_DEPTH];
    int             written_idx[$]; // entries known to hold a value, for legal lookups

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // drive one transfer and wait for it to be taken
    task automatic send_item(t_req r);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.func        <= r.func;
        pix_in.table_index <= r.table_index;
        pix_in.table_value <= r.table_value;
        pix_in.chan_x      <= r.chan_x;
        pix_in.chan_y      <= r.chan_y;
        pix_in.chan_z      <= r.chan_z;
        do @(posedge i_clk); while (!pix_in.ready);
        sb.note_input(r);
        if (r.func == FUNC_WRITE && r.table_index < TABLE_DEPTH
            && !written[r.table_index]) begin
            written[r.table_index] = 1'b1;
            written_idx.push_back(r.table_index);
        end
        @(negedge i_clk);
    endtask

    task automatic write_entry(int idx, int val);
        t_req r;
        r.func        = FUNC_WRITE;
        r.table_index = t_chan'(idx);
        r.table_value = t_chan'(val);
        r.chan_x      = t_chan'($urandom);
        r.chan_y      = t_chan'($urandom);
        r.chan_z      = t_chan'($urandom);
        send_item(r);
    endtask

    // pixel whose maximum lands on a written entry (lookup saturates at the top)
    task automatic send_pixel(int px, int py, int pz);
        t_req r;
        r.func        = FUNC_PIXEL;
        r.table_index = t_chan'($urandom);
        r.table_value = t_chan'($urandom);
        r.chan_x      = t_chan'(px);
        r.chan_y      = t_chan'(py);
        r.chan_z      = t_chan'(pz);
        send_item(r);
    endtask

    // random pixel with its peak on a written entry and the rest at or below it
    task automatic random_pixel();
        int peak;
        int lane;
        int ch[3];
        peak = written_idx[$urandom_range(0, written_idx.size() - 1)];
        if (peak == 0) begin
            send_pixel(0, 0, 0);
        end else begin
            lane = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
                ch[k] = (k == lane) ? peak : $urandom_range(0, peak);
            send_pixel(ch[0], ch[1], ch[2]);
        end
    endtask

    // output side: random stall per transfer, plus the long hold-off
    initial begin
        int stall;
        pix_out.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                pix_out.ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end
            stall = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall != 0) begin
                pix_out.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pix_out.ready <= 1'b1;
            do @(posedge i_clk); while (!pix_out.valid);
        end
    end

    // checker samples at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready)
            sb.check_result('{x: pix_out.out_x, y: pix_out.out_y, z: pix_out.out_z});
    end

    initial begin
        int wait_cyc;
        sb                 = new();
        hold_off           = 1'b0;
        i_rst_n            = 1'b0;
        pix_in.valid       = 1'b0;
        pix_in.func        = FUNC_WRITE;
        pix_in.table_index = '0;
        pix_in.table_value = '0;
        pix_in.chan_x      = '0;
        pix_in.chan_y      = '0;
        pix_in.chan_z      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: table corners, black pixel, saturated lookup
        write_entry(0, 0);
        write_entry(1, 32768);
        write_entry(TABLE_DEPTH - 1, 65535);
        write_entry(65535, 32768);
        write_entry(32768, 16384);
        write_entry(2, 1);
        write_entry(65534, 0);
        send_pixel(0, 0, 0);
        send_pixel(1, 0, 0);
        send_pixel(0, 1, 1);
        send_pixel(65535, 65535, 65535);
        send_pixel(65535, 0, 32767);
        send_pixel(1, 65535, 12345);
        send_pixel(32768, 16384, 1);
        send_pixel(2, 1, 2);
        send_pixel(65534, 65534, 0);
        send_pixel(43690, 21845, 65535);

        // random: mostly pixels over a growing table, some writes
        for (int n = 0; n < 1830; n++) begin
            if (n == 600)
                hold_off = 1'b1;
            if ($urandom_range(0, 3) == 0)
                write_entry($urandom_range(0, 65535), $urandom_range(0, 65535));
            else
                random_pixel();
        end
        pix_in.valid <= 1'b0;

        wait_cyc = 0;
        while (sb.owed_pix.size() != 0 && wait_cyc < 20000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_pix.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // overall limit, several times the slowest correct run
    initial begin
        #200000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
